/* hdl/rasinh_pkg.sv */
// Shared constants and types for the fixed-point inverse hyperbolic sine pipeline.
// Used by rasinh_sqrt_cell, rasinh_log_cell and real_asinh_fixed_point.
// No dependencies.
package rasinh_pkg;

    // Fraction bits of input and result (Q16.16 by default, 8..24 supported).
    localparam int FRAC_BITS = 16;

    // Field widths fixed by the stream format.
    localparam int X_W      = 32;
    localparam int Y_W      = 21;
    localparam int S_DATA_W = ((X_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((Y_W + 7) / 8) * 8;

    // Square-root datapath.
    localparam int RAD_W  = 64;             // normalized radicand
    localparam int PAIRS  = RAD_W / 2;      // digit pairs = root bits
    localparam int ROOT_W = PAIRS;
    localparam int REM_W  = ROOT_W + 3;     // partial remainder after 2-bit shift
    localparam int H_W    = 5;              // pair shift count, at most 31 - FRAC_BITS

    // Log datapath.
    localparam int S_W    = ROOT_W + 1;     // x + sqrt(x*x+1), scaled
    localparam int E_W    = 6;              // exponent of S
    localparam int IP_W   = E_W;            // integer part of log2
    localparam int M_W    = 32;             // mantissa in [2^31, 2^32)
    localparam int LFR_W  = 32;             // log2 fraction bits
    localparam int IPL_W  = IP_W + 32;      // ip * ln2
    localparam int T_W    = IPL_W + 1;      // natural log, 2^-32 units
    localparam int SHR    = 32 - FRAC_BITS;
    localparam int MAG_W  = T_W - SHR;
    localparam int SAT_W  = (MAG_W > Y_W) ? MAG_W : Y_W + 1;

    // round(ln2 * 2^32)
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    // The value 1.0 squared, in 2^-(2F) units.
    localparam logic [RAD_W-1:0] ONE_SQ = RAD_W'(1) << (2 * FRAC_BITS);

    // Round-to-nearest bias ahead of the final shift.
    localparam logic [T_W-1:0] ROUND_BIAS = T_W'(1) << (SHR - 1);

    // Saturation codes of the result.
    localparam logic [Y_W-1:0] Y_MAX_CODE = {1'b0, {(Y_W - 1){1'b1}}};
    localparam logic [Y_W-1:0] Y_MIN_CODE = {1'b1, {(Y_W - 1){1'b0}}};

    // Sideband carried along the square-root chain.
    typedef struct packed {
        logic           valid;
        logic           neg;
        logic           last;
        logic [H_W-1:0] h;
        logic [31:0]    ah;     // |x| << h
    } sq_side_t;

    // Sideband carried along the log chain.
    typedef struct packed {
        logic            valid;
        logic            neg;
        logic            last;
        logic [IP_W-1:0] ip;
    } lg_side_t;

endpackage

/* hdl/real_asinh_fixed_point.sv */
// Top level of the fixed-point inverse hyperbolic sine stream block.
// Depends on rasinh_pkg, rasinh_sqrt_cell and rasinh_log_cell.
//
// Computes y = asinh(x) = ln(x + sqrt(x*x + 1)) for each signed fixed-point
// sample (FRAC_BITS fraction bits, Q16.16 by default) and returns it rounded to
// nearest (ties away from zero) as a 21-bit signed value with the same fraction
// bits, saturated to the result range. The work is done on |x| and the sign put
// back at the end, so the result is exactly odd; the most negative input maps to
// the negation of the result for +2^31. tlast rides along unchanged. The block
// takes one request per clock while s_tready is high and has 75 register stages.
// The stages are four front stages (abs, square, pair-normalize, shift), a chain
// of 32 square-root cells (one root bit each), three stages that form
// x + sqrt(x*x+1) and normalize it, a chain of 32 log cells (one log2 fraction
// bit each, one 32x32 square per cell), three stages that scale by ln2, round
// and saturate, and the output register. A two-entry output stage (output
// register plus skid) lets the pipeline keep moving while a result waits; when
// both are full the whole pipeline holds and s_tready drops.
module real_asinh_fixed_point
    import rasinh_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,    // [31:0] x_value
    input  logic                s_tlast,    // last_in
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,    // [20:0] y_value, upper bits zero
    output logic                m_tlast     // last_out
);

    // Global advance: the pipeline moves unless the skid entry is occupied.
    logic skid_valid_reg;
    logic en;
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // ---------------- Stage 0: magnitude ----------------
    logic           v0_reg, neg0_reg, last0_reg;
    logic [X_W-1:0] a0_reg;
    logic [X_W-1:0] x_in;
    logic [X_W-1:0] a0_next;

    assign x_in    = s_tdata[X_W-1:0];
    assign a0_next = x_in[X_W-1] ? (~x_in + X_W'(1)) : x_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg0_reg  <= x_in[X_W-1];
            last0_reg <= s_tlast;
            a0_reg    <= a0_next;
        end
    end

    // ---------------- Stage 1: square ----------------
    logic             v1_reg, neg1_reg, last1_reg;
    logic [X_W-1:0]   a1_reg;
    logic [RAD_W-1:0] aa1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg1_reg  <= neg0_reg;
            last1_reg <= last0_reg;
            a1_reg    <= a0_reg;
            aa1_reg   <= RAD_W'(a0_reg) * RAD_W'(a0_reg);
        end
    end

    // ---------------- Stage 2: add 1.0, find pair shift ----------------
    // h = number of 2-bit shifts that bring the top set bit to 62 or 63.
    logic             v2_reg, neg2_reg, last2_reg;
    logic [X_W-1:0]   a2_reg;
    logic [RAD_W-1:0] q2_reg;
    logic [H_W-1:0]   h2_reg;
    logic [RAD_W-1:0] q2_next;
    logic [H_W-1:0]   h2_next;

    always_comb begin
        q2_next = aa1_reg + ONE_SQ;
        h2_next = '0;
        for (int j = 0; j < PAIRS; j++) begin
            if (q2_next[2*j +: 2] != 2'b00) begin
                h2_next = H_W'(PAIRS - 1 - j);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg2_reg  <= neg1_reg;
            last2_reg <= last1_reg;
            a2_reg    <= a1_reg;
            q2_reg    <= q2_next;
            h2_reg    <= h2_next;
        end
    end

    // ---------------- Stage 3: normalize radicand and |x| ----------------
    sq_side_t         side3_reg;
    logic [RAD_W-1:0] qn3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side3_reg.valid <= 1'b0;
        end else if (en) begin
            side3_reg.valid <= v2_reg;
            side3_reg.neg   <= neg2_reg;
            side3_reg.last  <= last2_reg;
            side3_reg.h     <= h2_reg;
            side3_reg.ah    <= a2_reg << h2_reg;    // fits: (a<<h)^2 < 2^64
            qn3_reg         <= q2_reg << {h2_reg, 1'b0};
        end
    end

    // ---------------- Square-root chain ----------------
    sq_side_t          sq_side [0:ROOT_W];
    logic [RAD_W-1:0]  sq_rad  [0:ROOT_W];
    logic [REM_W-1:0]  sq_rem  [0:ROOT_W];
    logic [ROOT_W-1:0] sq_root [0:ROOT_W];

    assign sq_side[0] = side3_reg;
    assign sq_rad[0]  = qn3_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
        rasinh_sqrt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .side_in  (sq_side[i]),
            .rad_in   (sq_rad[i]),
            .rem_in   (sq_rem[i]),
            .root_in  (sq_root[i]),
            .side_out (sq_side[i+1]),
            .rad_out  (sq_rad[i+1]),
            .rem_out  (sq_rem[i+1]),
            .root_out (sq_root[i+1])
        );
    end

    sq_side_t sq_end;
    assign sq_end = sq_side[ROOT_W];

    // ---------------- Stage 4: S = (|x| << h) + sqrt ----------------
    logic           v4_reg, neg4_reg, last4_reg;
    logic [H_W-1:0] h4_reg;
    logic [S_W-1:0] sum4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= sq_end.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg4_reg  <= sq_end.neg;
            last4_reg <= sq_end.last;
            h4_reg    <= sq_end.h;
            sum4_reg  <= S_W'(sq_end.ah) + S_W'(sq_root[ROOT_W]);
        end
    end

    // ---------------- Stage 5: exponent of S ----------------
    logic           v5_reg, neg5_reg, last5_reg;
    logic [H_W-1:0] h5_reg;
    logic [S_W-1:0] sum5_reg;
    logic [E_W-1:0] e5_reg;
    logic [E_W-1:0] e5_next;

    always_comb begin
        e5_next = '0;
        for (int i = 0; i < S_W; i++) begin
            if (sum4_reg[i]) begin
                e5_next = E_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg5_reg  <= neg4_reg;
            last5_reg <= last4_reg;
            h5_reg    <= h4_reg;
            sum5_reg  <= sum4_reg;
            e5_reg    <= e5_next;
        end
    end

    // ---------------- Stage 6: mantissa into [2^31, 2^32), integer log2 ----------------
    lg_side_t       side6_reg;
    logic [M_W-1:0] m6_reg;
    logic [M_W-1:0] m6_next;
    logic [S_W-1:0] sum_sh;

    always_comb begin
        if (e5_reg >= E_W'(M_W - 1)) begin
            sum_sh = sum5_reg >> (e5_reg - E_W'(M_W - 1));     // truncates
        end else begin
            sum_sh = sum5_reg << (E_W'(M_W - 1) - e5_reg);
        end
        m6_next = sum_sh[M_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side6_reg.valid <= 1'b0;
        end else if (en) begin
            side6_reg.valid <= v5_reg;
            side6_reg.neg   <= neg5_reg;
            side6_reg.last  <= last5_reg;
            side6_reg.ip    <= e5_reg - IP_W'(FRAC_BITS) - IP_W'(h5_reg);
            m6_reg          <= m6_next;
        end
    end

    // ---------------- Log2 fraction chain ----------------
    lg_side_t         lg_side [0:LFR_W];
    logic [M_W-1:0]   lg_m    [0:LFR_W];
    logic [LFR_W-1:0] lg_frac [0:LFR_W];

    assign lg_side[0] = side6_reg;
    assign lg_m[0]    = m6_reg;
    assign lg_frac[0] = '0;

    for (genvar i = 0; i < LFR_W; i++) begin : g_log
        rasinh_log_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .side_in  (lg_side[i]),
            .m_in     (lg_m[i]),
            .frac_in  (lg_frac[i]),
            .side_out (lg_side[i+1]),
            .m_out    (lg_m[i+1]),
            .frac_out (lg_frac[i+1])
        );
    end

    lg_side_t lg_end;
    assign lg_end = lg_side[LFR_W];

    // ---------------- Stage 7: scale by ln2 ----------------
    logic             v7_reg, neg7_reg, last7_reg;
    logic [63:0]      prod7_reg;
    logic [IPL_W-1:0] ipl7_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v7_reg <= 1'b0;
        end else if (en) begin
            v7_reg <= lg_end.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg7_reg  <= lg_end.neg;
            last7_reg <= lg_end.last;
            prod7_reg <= 64'(lg_frac[LFR_W]) * 64'(LN2_Q32);
            ipl7_reg  <= IPL_W'(lg_end.ip) * IPL_W'(LN2_Q32);
        end
    end

    // ---------------- Stage 8: sum and round ----------------
    logic             v8_reg, neg8_reg, last8_reg;
    logic [MAG_W-1:0] mag8_reg;
    logic [T_W-1:0]   t8_next;

    assign t8_next = T_W'(ipl7_reg) + T_W'(prod7_reg[63:32]) + ROUND_BIAS;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v8_reg <= 1'b0;
        end else if (en) begin
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg8_reg  <= neg7_reg;
            last8_reg <= last7_reg;
            mag8_reg  <= t8_next[T_W-1:SHR];
        end
    end

    // ---------------- Stage 9: sign and saturate ----------------
    logic             v9_reg, last9_reg;
    logic [Y_W-1:0]   y9_reg;
    logic [SAT_W-1:0] mag_ext;
    logic [Y_W-1:0]   mag_y;
    logic [Y_W-1:0]   y9_next;

    always_comb begin
        mag_ext = SAT_W'(mag8_reg);
        mag_y   = mag_ext[Y_W-1:0];
        if (neg8_reg) begin
            if (mag_ext > (SAT_W'(1) << (Y_W - 1))) begin
                y9_next = Y_MIN_CODE;
            end else begin
                y9_next = ~mag_y + Y_W'(1);
            end
        end else begin
            if (mag_ext > SAT_W'(Y_MAX_CODE)) begin
                y9_next = Y_MAX_CODE;
            end else begin
                y9_next = mag_y;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v9_reg <= 1'b0;
        end else if (en) begin
            v9_reg <= v8_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            last9_reg <= last8_reg;
            y9_reg    <= y9_next;
        end
    end

    // ---------------- Output register and skid ----------------
    // A finished request goes to the output register if it is free or being
    // taken, otherwise into the skid entry, which then holds the pipeline.
    logic           out_valid_reg;
    logic [Y_W-1:0] out_y_reg, skid_y_reg;
    logic           out_last_reg, skid_last_reg;
    logic           out_take;
    logic           pipe_out;

    assign out_take = out_valid_reg && m_tready;
    assign pipe_out = en && v9_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_take) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (pipe_out) begin
            if (!out_valid_reg || m_tready) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (out_take) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_take) begin
                out_y_reg    <= skid_y_reg;
                out_last_reg <= skid_last_reg;
            end
        end else if (pipe_out) begin
            if (!out_valid_reg || m_tready) begin
                out_y_reg    <= y9_reg;
                out_last_reg <= last9_reg;
            end else begin
                skid_y_reg    <= y9_reg;
                skid_last_reg <= last9_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'(out_y_reg);
    assign m_tlast  = out_last_reg;

endmodule

/* hdl/rasinh_sqrt_cell.sv */
// One cell of the square-root chain: resolves one root bit per request.
// Depends on rasinh_pkg.
module rasinh_sqrt_cell
    import rasinh_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  sq_side_t          side_in,
    input  logic [RAD_W-1:0]  rad_in,
    input  logic [REM_W-1:0]  rem_in,
    input  logic [ROOT_W-1:0] root_in,
    output sq_side_t          side_out,
    output logic [RAD_W-1:0]  rad_out,
    output logic [REM_W-1:0]  rem_out,
    output logic [ROOT_W-1:0] root_out
);

    sq_side_t          side_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_next;

    always_comb begin
        rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1:RAD_W-2]};
        trial  = {1'b0, root_in, 2'b01};
        if (rem_sh >= trial) begin
            rem_next  = rem_sh - trial;
            root_next = {root_in[ROOT_W-2:0], 1'b1};
        end else begin
            rem_next  = rem_sh;
            root_next = {root_in[ROOT_W-2:0], 1'b0};
        end
    end

    // Only the valid bit is reset; the rest follows it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg.valid <= 1'b0;
        end else if (en) begin
            side_reg.valid <= side_in.valid;
            side_reg.neg   <= side_in.neg;
            side_reg.last  <= side_in.last;
            side_reg.h     <= side_in.h;
            side_reg.ah    <= side_in.ah;
            rad_reg        <= rad_in << 2;
            rem_reg        <= rem_next;
            root_reg       <= root_next;
        end
    end

    assign side_out = side_reg;
    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

/* hdl/rasinh_log_cell.sv */
// One cell of the log2 chain: squares the mantissa and yields one fraction bit.
// Depends on rasinh_pkg.
module rasinh_log_cell
    import rasinh_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  lg_side_t         side_in,
    input  logic [M_W-1:0]   m_in,
    input  logic [LFR_W-1:0] frac_in,
    output lg_side_t         side_out,
    output logic [M_W-1:0]   m_out,
    output logic [LFR_W-1:0] frac_out
);

    lg_side_t         side_reg;
    logic [M_W-1:0]   m_reg;
    logic [LFR_W-1:0] frac_reg;

    logic [2*M_W-1:0] sq;
    logic [M_W:0]     sq_sh;
    logic             bit_next;
    logic [M_W-1:0]   m_next;

    always_comb begin
        sq       = (2*M_W)'(m_in) * (2*M_W)'(m_in);
        sq_sh    = sq[2*M_W-1:M_W-1];
        bit_next = sq_sh[M_W];
        m_next   = bit_next ? sq_sh[M_W:1] : sq_sh[M_W-1:0];
    end

    // Only the valid bit is reset; the rest follows it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg.valid <= 1'b0;
        end else if (en) begin
            side_reg.valid <= side_in.valid;
            side_reg.neg   <= side_in.neg;
            side_reg.last  <= side_in.last;
            side_reg.ip    <= side_in.ip;
            m_reg          <= m_next;
            frac_reg       <= {frac_in[LFR_W-2:0], bit_next};
        end
    end

    assign side_out = side_reg;
    assign m_out    = m_reg;
    assign frac_out = frac_reg;

endmodule

/* tb/real_asinh_fixed_point_test.sv */
// Self-checking regression for the real_asinh_fixed_point stream block.
// Depends on rasinh_pkg and the block RTL; holds its own bit-exact asinh predictor.
`timescale 1ns / 100ps

module real_asinh_fixed_point_test;
    import rasinh_pkg::*;

    // One input request and one predicted result.
    typedef struct {
        logic [X_W-1:0] x;
        logic           last;
        bit             drain;      // hold this request until the pipe is empty
    } sample_req_t;

    typedef struct {
        logic [Y_W-1:0] y;
        logic           last;
    } asinh_res_t;

    localparam int NUM_RANDOM   = 1750;
    localparam int STALL_CYCLES = 400;      // long receiver hold-off
    localparam int STALL_AT     = 300;      // results seen before the hold-off
    localparam int CALM_LO      = 900;      // no idling inside this window
    localparam int CALM_HI      = 1200;
    localparam int DRAIN_AT     = 1350;     // request index that waits for an empty pipe
    localparam int TAIL_CYCLES  = 120;      // idle tail after the last result

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tlast  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;

    sample_req_t sample_q[$];   // requests not yet offered
    asinh_res_t  y_due[$];      // predicted results, oldest first

    logic in_fire = 1'b0;       // request accepted at the last rising edge
    int   sent_cnt     = 0;
    int   result_cnt   = 0;
    int   neg_cnt      = 0;
    int   last_cnt     = 0;
    int   mismatch_cnt = 0;
    int   in_stall_cyc = 0;     // cycles with s_tvalid high and s_tready low
    int   hold_left    = 0;
    bit   hold_done    = 1'b0;

    real_asinh_fixed_point dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [31:0] x_value
        .s_tlast  (s_tlast),    // last_in
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [20:0] y_value, upper bits zero
        .m_tlast  (m_tlast)     // last_out
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Bit-exact asinh on |x|: normalize x*x+1 by bit pairs, integer root,
    // log2 of the sum bit by bit, scale by ln2, round, then restore the sign.
    function automatic logic [Y_W-1:0] asinh_fixed(logic [X_W-1:0] x);
        logic [63:0] mag, rad, root, bitv, rem, sum, mant, lfrac, ipart, lnv, ymag;
        int unsigned shifts, expo;
        logic        neg;
        neg  = x[X_W-1];
        // most negative input keeps magnitude 2^31
        mag  = neg ? (64'h1_0000_0000 - {32'b0, x}) : {32'b0, x};
        rad  = mag * mag + (64'd1 << (2 * FRAC_BITS));
        shifts = 0;
        while (rad < (64'd1 << 62)) begin
            rad = rad << 2;
            shifts++;
        end
        rem  = rad;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        sum  = (mag << shifts) + root;
        expo = 0;
        while ((sum >> expo) > 1)
            expo++;
        // mantissa into [2^31, 2^32), low bits truncated
        mant = (expo >= 31) ? (sum >> (expo - 31)) : (sum << (31 - expo));
        lfrac = '0;
        for (int i = 0; i < 32; i++) begin
            mant  = (mant * mant) >> 31;
            lfrac = lfrac << 1;
            if (mant >= (64'd1 << 32)) begin
                mant  = mant >> 1;
                lfrac = lfrac | 64'd1;
            end
        end
        ipart = 64'(expo - FRAC_BITS - shifts);
        lnv   = ipart * 64'(LN2_Q32) + ((lfrac * 64'(LN2_Q32)) >> 32);
        ymag  = (lnv + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
        if (neg)
            return (ymag > 64'd1048576) ? Y_MIN_CODE : Y_W'(~ymag + 64'd1);
        else
            return (ymag > 64'd1048575) ? Y_MAX_CODE : ymag[Y_W-1:0];
    endfunction

    // Random sample: a mix of full range, the steep region near zero,
    // values around powers of two and the extremes.
    function automatic logic [X_W-1:0] pick_sample();
        int unsigned sel, sh;
        logic [X_W-1:0] v;
        sel = $urandom_range(99);
        if (sel < 30) begin
            v = $urandom;
        end else if (sel < 60) begin
            v = X_W'($signed($urandom_range(524287)) - 262144);     // -4.0 <= x < 4.0
        end else if (sel < 78) begin
            v = X_W'($signed($urandom_range(8191)) - 4096);         // tiny
        end else if (sel < 92) begin
            sh = $urandom_range(30);
            v  = (X_W'(1) << sh) + X_W'($urandom_range(4)) - X_W'(2);
            if ($urandom_range(1))
                v = -v;
        end else begin
            case ($urandom_range(5))
                0: v = '0;
                1: v = 32'h7FFF_FFFF;
                2: v = 32'h8000_0000;
                3: v = 32'h0001_0000;
                4: v = 32'hFFFF_0000;
                default: v = 32'hFFFF_FFFF;
            endcase
        end
        return v;
    endfunction

    // Driver: change inputs on the falling edge; hold a request until accepted.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !in_fire) begin
            // request still pending, keep it stable
        end else if (sample_q.size() == 0) begin
            s_tvalid <= 1'b0;
        end else if (sample_q[0].drain && y_due.size() != 0) begin
            s_tvalid <= 1'b0;           // pause until every result is back
        end else if (!(sent_cnt >= CALM_LO && sent_cnt < CALM_HI) &&
                     $urandom_range(99) < 24) begin
            s_tvalid <= 1'b0;
        end else begin
            s_tdata  <= sample_q[0].x;
            s_tlast  <= sample_q[0].last;
            s_tvalid <= 1'b1;
            void'(sample_q.pop_front());
        end
    end

    // Receiver ready: random stalls, one long hold-off, a calm window.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && result_cnt >= STALL_AT) begin
            m_tready  <= 1'b0;
            hold_left <= STALL_CYCLES - 1;
            hold_done <= 1'b1;
        end else if (result_cnt >= CALM_LO && result_cnt < CALM_HI) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= 24);
        end
    end

    // Monitor: sample on the rising edge, predict on accept, check on result.
    always @(posedge aclk) begin
        asinh_res_t due;
        if (!aresetn) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= s_tvalid && s_tready;
            if (s_tvalid && !s_tready)
                in_stall_cyc <= in_stall_cyc + 1;
            if (s_tvalid && s_tready) begin
                due.y    = asinh_fixed(s_tdata[X_W-1:0]);
                due.last = s_tlast;
                y_due.push_back(due);
                sent_cnt <= sent_cnt + 1;
                if (s_tdata[X_W-1])
                    neg_cnt <= neg_cnt + 1;
                if (s_tlast)
                    last_cnt <= last_cnt + 1;
            end
            if (m_tvalid && m_tready) begin
                result_cnt <= result_cnt + 1;
                if (y_due.size() == 0) begin
                    mismatch_cnt <= mismatch_cnt + 1;
                    if (mismatch_cnt < 10)
                        $display("%0t: result with no request pending: tdata=%h tlast=%b",
                                 $realtime, m_tdata, m_tlast);
                end else begin
                    due = y_due.pop_front();
                    if (m_tdata !== M_DATA_W'(due.y) || m_tlast !== due.last) begin
                        mismatch_cnt <= mismatch_cnt + 1;
                        if (mismatch_cnt < 10)
                            $display("%0t: result %0d: y exp %h got %h, last exp %b got %b",
                                     $realtime, result_cnt, due.y, m_tdata,
                                     due.last, m_tlast);
                    end
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        logic [X_W-1:0] dir_vals[$];
        sample_req_t    req;
        dir_vals = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000,
                     32'hFFFF_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                     32'h0000_8000, 32'hFFFF_8000, 32'h0002_0000, 32'h0010_0000,
                     32'h4000_0000, 32'hC000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
                     32'h0000_0100, 32'hFFFF_FF00, 32'h00FF_FFFF, 32'h7FFF_0000};
        foreach (dir_vals[i]) begin
            req.x     = dir_vals[i];
            req.last  = i[0];
            req.drain = 1'b0;
            sample_q.push_back(req);
        end
        for (int i = 0; i < NUM_RANDOM; i++) begin
            req.x     = pick_sample();
            req.last  = ($urandom_range(7) == 0);
            req.drain = (i == DRAIN_AT);
            sample_q.push_back(req);
        end

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (sample_q.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (y_due.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d requests (%0d negative, %0d with tlast), %0d results checked",
                 sent_cnt, neg_cnt, last_cnt, result_cnt);
        $display("input backpressure seen on %0d cycles, %0d mismatches",
                 in_stall_cyc, mismatch_cnt);
        if (mismatch_cnt == 0 && y_due.size() == 0) begin
            $display("real_asinh_fixed_point regression: pass");
        end else begin
            $display("real_asinh_fixed_point regression: fail");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("real_asinh_fixed_point regression: fail");
        $finish;
    end

endmodule
